/* rtl/core/assert_macros.svh */
// Assertion macros shared by the label agreement RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lap_pkg.sv */
// Shared types, constants and the logarithm table of the label agreement block.
`default_nettype none
package lap_pkg;
   localparam int LABEL_W     = 8;
   localparam int MAP_MAX     = 8;
   localparam int COUNT_W     = 4;
   localparam int VALUE_W     = 24;
   localparam int FRAC_W      = 16;
   localparam int LN_W        = 18;
   localparam int CSR_INDEX_W = 3;

   localparam logic [VALUE_W-1:0] Q_ONE = 24'h010000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LABEL_ID     = 3'd0,
      CSR_ENTROPY_ON   = 3'd1,
      CSR_NORMALIZE_ON = 3'd2,
      CSR_MAX_VALUE    = 3'd3,
      CSR_PRESENT_MASK = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] agree;
      logic               err;
      logic               bypass;
      logic [VALUE_W-1:0] value;
   } lap_side_type;

   // Natural logarithm of a map count in unsigned Q2.16, rounded to nearest.
   function automatic logic [LN_W-1:0] ln_q16(input logic [COUNT_W-1:0] n);
      case (n)
         4'd2:    return 18'd45426;
         4'd3:    return 18'd71999;
         4'd4:    return 18'd90852;
         4'd5:    return 18'd105476;
         4'd6:    return 18'd117425;
         4'd7:    return 18'd127527;
         4'd8:    return 18'd136278;
         default: return '0;
      endcase
   endfunction
endpackage
`default_nettype wire

/* rtl/core/label_agreement_probability.sv */
// Top level of the label agreement probability and entropy block.
`default_nettype none
`include "assert_macros.svh"
// One word enters per clock while rsp_ready keeps the pipeline moving: each voxel's
// labels are counted against label_id, the counts index a logarithm table, and every
// quotient goes through a sixteen-stage divider with one quotient bit per stage. The
// sustained rate is one word per cycle while rsp_ready is held; a stalled result holds
// only the stages behind it that are full, so empty stages keep filling.
// Configuration is taken through the csr_ port whenever reset is low, but it is meant
// to change only while no voxel is in flight.
module label_agreement_probability import lap_pkg::*; #(
   parameter int NUM_MAPS   = 8,
   parameter int LABEL_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [LABEL_W-1:0]     req_label_0,
   input  wire logic [LABEL_W-1:0]     req_label_1,
   input  wire logic [LABEL_W-1:0]     req_label_2,
   input  wire logic [LABEL_W-1:0]     req_label_3,
   input  wire logic [LABEL_W-1:0]     req_label_4,
   input  wire logic [LABEL_W-1:0]     req_label_5,
   input  wire logic [LABEL_W-1:0]     req_label_6,
   input  wire logic [LABEL_W-1:0]     req_label_7,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [VALUE_W-1:0]          rsp_term_value,
   output logic [COUNT_W-1:0]          rsp_agree_count,
   output logic                        rsp_no_maps_error,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [VALUE_W-1:0]     csr_data
);
   localparam int CMP_BITS = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;

   logic [LABEL_W-1:0] cfg_label_id_ff;
   logic               cfg_entropy_ff;
   logic               cfg_normalize_ff;
   logic [VALUE_W-1:0] cfg_max_ff;
   logic [MAP_MAX-1:0] cfg_present_mask_ff;

   logic [LABEL_W-1:0] labels [0:MAP_MAX-1];
   logic [COUNT_W-1:0] present_in;
   logic [COUNT_W-1:0] agree_in;

   logic               s1_vld_ff;
   logic [COUNT_W-1:0] s1_present_ff;
   logic [COUNT_W-1:0] s1_agree_ff;
   logic               s1_entropy_ff;
   logic               s1_normalize_ff;
   logic [VALUE_W-1:0] s1_max_ff;
   logic               s1_ready;

   logic               s2_vld_ff;
   logic [COUNT_W-1:0] s2_present_ff;
   logic [COUNT_W-1:0] s2_agree_ff;
   logic [LN_W-1:0]    s2_diff_ff;
   logic               s2_entropy_ff;
   logic               s2_normalize_ff;
   logic [VALUE_W-1:0] s2_max_ff;
   logic               s2_ready;
   logic [LN_W-1:0]    diff_in;

   logic               div_in_ready;
   logic [VALUE_W-1:0] div_num;
   logic [VALUE_W-1:0] div_den;
   lap_side_type       div_side;
   logic               div_out_valid;
   logic [FRAC_W-1:0]  div_out_quo;
   lap_side_type       div_out_side;
   logic               out_ready;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_term_value_ff;
   logic [COUNT_W-1:0] rsp_agree_count_ff;
   logic               rsp_no_maps_error_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_label_id_ff     <= 8'd1;
         cfg_entropy_ff      <= 1'b0;
         cfg_normalize_ff    <= 1'b0;
         cfg_max_ff          <= 24'd6553600;
         cfg_present_mask_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LABEL_ID:     cfg_label_id_ff     <= csr_data[LABEL_W-1:0];
            CSR_ENTROPY_ON:   cfg_entropy_ff      <= csr_data[0];
            CSR_NORMALIZE_ON: cfg_normalize_ff    <= csr_data[0];
            CSR_MAX_VALUE:    cfg_max_ff          <= csr_data;
            CSR_PRESENT_MASK: cfg_present_mask_ff <= csr_data[MAP_MAX-1:0];
            default: ;
         endcase
      end
   end

   assign labels[0] = req_label_0;
   assign labels[1] = req_label_1;
   assign labels[2] = req_label_2;
   assign labels[3] = req_label_3;
   assign labels[4] = req_label_4;
   assign labels[5] = req_label_5;
   assign labels[6] = req_label_6;
   assign labels[7] = req_label_7;

   always_comb begin
      present_in = '0;
      agree_in   = '0;
      for (int i = 0; i < MAP_MAX; i++) begin
         if (i < NUM_MAPS && cfg_present_mask_ff[i]) begin
            present_in = present_in + COUNT_W'(1);
            if (labels[i][CMP_BITS-1:0] == cfg_label_id_ff[CMP_BITS-1:0]) begin
               agree_in = agree_in + COUNT_W'(1);
            end
         end
      end
   end

   assign s2_ready  = !s2_vld_ff || div_in_ready;
   assign s1_ready  = !s1_vld_ff || s2_ready;
   assign req_ready = !reset && s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   assign diff_in = ln_q16(s1_present_ff) - ln_q16(s1_agree_ff);

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_present_ff   <= present_in;
         s1_agree_ff     <= agree_in;
         s1_entropy_ff   <= cfg_entropy_ff;
         s1_normalize_ff <= cfg_normalize_ff;
         s1_max_ff       <= cfg_max_ff;
      end
      if (s2_ready && s1_vld_ff) begin
         s2_present_ff   <= s1_present_ff;
         s2_agree_ff     <= s1_agree_ff;
         s2_diff_ff      <= diff_in;
         s2_entropy_ff   <= s1_entropy_ff;
         s2_normalize_ff <= s1_normalize_ff;
         s2_max_ff       <= s1_max_ff;
      end
   end

   always_comb begin
      div_side.agree  = s2_agree_ff;
      div_side.err    = 1'b0;
      div_side.bypass = 1'b1;
      div_side.value  = '0;
      div_num         = '0;
      div_den         = s2_max_ff;
      if (s2_present_ff == '0) begin
         div_side.err = 1'b1;
      end else if (s2_entropy_ff) begin
         if (s2_agree_ff == '0) begin
            div_side.value = s2_normalize_ff ? Q_ONE : s2_max_ff;
         end else if (s2_normalize_ff) begin
            if (VALUE_W'(s2_diff_ff) < s2_max_ff) begin
               div_side.bypass = 1'b0;
               div_num         = VALUE_W'(s2_diff_ff);
            end else begin
               div_side.value = Q_ONE;
            end
         end else begin
            div_side.value = VALUE_W'(s2_diff_ff);
         end
      end else if (s2_agree_ff == s2_present_ff) begin
         div_side.value = Q_ONE;
      end else begin
         div_side.bypass = 1'b0;
         div_num         = VALUE_W'(s2_agree_ff);
         div_den         = VALUE_W'(s2_present_ff);
      end
   end

   lap_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_vld_ff),
      .in_ready  (div_in_ready),
      .in_num    (div_num),
      .in_den    (div_den),
      .in_side   (div_side),
      .out_valid (div_out_valid),
      .out_ready (out_ready),
      .out_quo   (div_out_quo),
      .out_side  (div_out_side)
   );

   assign out_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && div_out_valid) begin
         rsp_term_value_ff    <= div_out_side.bypass ? div_out_side.value
                                                     : VALUE_W'(div_out_quo);
         rsp_agree_count_ff   <= div_out_side.agree;
         rsp_no_maps_error_ff <= div_out_side.err;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_term_value    = rsp_term_value_ff;
   assign rsp_agree_count   = rsp_agree_count_ff;
   assign rsp_no_maps_error = rsp_no_maps_error_ff;

   `ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && req_ready, s1_vld_ff, "Accepted word was not captured.")
   `ASSERT_IMP(a_agree_bound, clock, reset, s1_vld_ff, s1_agree_ff <= s1_present_ff, "Agreement exceeds present maps.")
   `ASSERT_IMP(a_error_result, clock, reset, rsp_valid_ff && rsp_no_maps_error_ff, rsp_term_value_ff == '0 && rsp_agree_count_ff == '0, "Error result is not zero.")
endmodule
`default_nettype wire

/* rtl/core/lap_div.sv */
// Pipelined restoring divider giving a sixteen-bit fraction, one quotient bit per stage.
`default_nettype none
`include "assert_macros.svh"
module lap_div import lap_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [VALUE_W-1:0] in_num,
   input  wire logic [VALUE_W-1:0] in_den,
   input  wire lap_side_type       in_side,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [FRAC_W-1:0]       out_quo,
   output lap_side_type            out_side
);
   localparam int STEPS = FRAC_W;

   logic [STEPS:0]     vld_ff;
   logic [STEPS:0]     stage_ready;
   logic [VALUE_W-1:0] rem_ff  [0:STEPS];
   logic [VALUE_W-1:0] den_ff  [0:STEPS];
   logic [FRAC_W-1:0]  quo_ff  [0:STEPS];
   lap_side_type       side_ff [0:STEPS];
   logic [VALUE_W:0]   shifted [1:STEPS];
   logic [VALUE_W-1:0] rem_in  [1:STEPS];
   logic [FRAC_W-1:0]  quo_in  [1:STEPS];

   always_comb begin
      stage_ready[STEPS] = !vld_ff[STEPS] || out_ready;
      for (int k = STEPS - 1; k >= 0; k--) begin
         stage_ready[k] = !vld_ff[k] || stage_ready[k+1];
      end
   end

   always_comb begin
      for (int k = 1; k <= STEPS; k++) begin
         shifted[k] = {rem_ff[k-1], 1'b0};
         if (shifted[k] >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = VALUE_W'(shifted[k] - {1'b0, den_ff[k-1]});
            quo_in[k] = {quo_ff[k-1][FRAC_W-2:0], 1'b1};
         end else begin
            rem_in[k] = shifted[k][VALUE_W-1:0];
            quo_in[k] = {quo_ff[k-1][FRAC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_ready[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k <= STEPS; k++) begin
            if (stage_ready[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0] && in_valid) begin
         rem_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
      for (int k = 1; k <= STEPS; k++) begin
         if (stage_ready[k] && vld_ff[k-1]) begin
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= quo_in[k];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = vld_ff[STEPS];
   assign out_quo   = quo_ff[STEPS];
   assign out_side  = side_ff[STEPS];

   `ASSERT_IMP(a_div_operands, clock, reset, in_valid && in_ready && !in_side.bypass, in_num < in_den, "Dividend is not below divisor.")
   `ASSERT_IMP(a_div_remainder, clock, reset, vld_ff[STEPS] && !side_ff[STEPS].bypass, rem_ff[STEPS] < den_ff[STEPS], "Final remainder is not below divisor.")
endmodule
`default_nettype wire
